/* rtl/core/bds2x_pkg.sv */
// ----------------------------------------------------------------------------
// bds2x_pkg
// Shared types and constants of the 2x2 box downsampler for RGBA streams.
// ----------------------------------------------------------------------------
`default_nettype none

package bds2x_pkg;

    // Pixel layout
    localparam int NUM_CHAN = 4;
    localparam int CHAN_W   = 8;
    localparam int PIX_W    = NUM_CHAN * CHAN_W;

    // Horizontal pair sum of one channel, and its slot in the line store
    localparam int HSUM_W       = CHAN_W + 1;
    localparam int LINE_FIELD_W = 10;
    localparam int LINE_W       = NUM_CHAN * LINE_FIELD_W;

    // Configuration
    localparam int DIM_W         = 13;
    localparam int MAX_WIDTH_DEF = 4096;
    localparam int HEIGHT_LIMIT  = 4096;
    localparam int ROW_W         = 12;
    localparam int CFG_IDX_W     = 1;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_IMAGE_WIDTH  = 1'b0;
    localparam cfg_idx_t REG_IMAGE_HEIGHT = 1'b1;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [HSUM_W-1:0] hsum_t;

endpackage

`default_nettype wire

/* rtl/core/bds2x_ram.sv */
// ----------------------------------------------------------------------------
// bds2x_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bds2x_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 2048,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write, and register the read word
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/core/box_downsample_2x_rgba.sv */
// ----------------------------------------------------------------------------
// box_downsample_2x_rgba
// 2x2 box-filter downsampler for a raster-order RGBA pixel stream.
// ----------------------------------------------------------------------------
// Takes one source pixel per clock and returns each output channel as
// (p00 + p10 + p01 + p11 + 2) / 4. An odd last column or row (dimension above
// one) is dropped; a dimension of one repeats the pixel as its own neighbour.
// Even rows leave horizontal pair sums in a line store of MAX_WIDTH/2 words;
// odd rows read them back through its registered read port. The completing
// pixel's transfer loads the pair stage; the result register takes it over,
// raising m_tvalid, once that register is empty or m_tready is high.
// Throughput is one pixel per clock, held back only by m_tready.
// The line store needs no clearing pass after reset. Write image_width and
// image_height only while the stream is idle; m_tlast marks the last result
// pixel of each image.
// ----------------------------------------------------------------------------
`default_nettype none

module box_downsample_2x_rgba #(
    parameter int MAX_WIDTH = bds2x_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // Configuration write port
    input  wire logic                         cfg_wr_en,
    input  wire bds2x_pkg::cfg_idx_t          cfg_addr,
    input  wire logic [bds2x_pkg::DIM_W-1:0]  cfg_wr_data,
    // Source pixels
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [bds2x_pkg::PIX_W-1:0]  s_tdata,   // chan0, chan1, chan2, chan3
    // Downsampled pixels
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [bds2x_pkg::PIX_W-1:0]       m_tdata,   // out_chan0..out_chan3
    output logic                              m_tlast    // last_of_image
);

    import bds2x_pkg::*;

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int AW   = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CW   = ($clog2(MAX_WIDTH) > 2) ? $clog2(MAX_WIDTH) : 2;
    localparam int XW   = CW - 1;
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (WW > DIM_W) ? WW : DIM_W;
    localparam int YW   = ROW_W - 1;

    // ------------------------------------------------------------------
    // Configuration, kept in derived form
    // ------------------------------------------------------------------
    logic          w_one_reg, w_one_next;
    logic [CW-1:0] w_m1_reg, w_m1_next;
    logic [XW-1:0] out_w_m1_reg, out_w_m1_next;
    logic             h_one_reg, h_one_next;
    logic [ROW_W-1:0] h_m1_reg, h_m1_next;
    logic [YW-1:0]    out_h_m1_reg, out_h_m1_next;

    logic [CMPW-1:0]  w_wide;
    logic [WW-1:0]    w_val;
    logic [DIM_W-1:0] h_val;

    // Clamp the written dimension and work out the limits it implies
    always_comb begin
        w_wide = CMPW'(cfg_wr_data);
        if (w_wide == '0) begin
            w_wide = CMPW'(1);
        end else if (w_wide > CMPW'(MAX_WIDTH)) begin
            w_wide = CMPW'(MAX_WIDTH);
        end
        w_val = WW'(w_wide);

        h_val = cfg_wr_data;
        if (h_val == '0) begin
            h_val = DIM_W'(1);
        end else if (h_val > DIM_W'(HEIGHT_LIMIT)) begin
            h_val = DIM_W'(HEIGHT_LIMIT);
        end

        w_one_next    = (w_val == WW'(1));
        w_m1_next     = CW'(w_val - WW'(1));
        out_w_m1_next = w_one_next ? '0 : XW'((w_val >> 1) - WW'(1));

        h_one_next    = (h_val == DIM_W'(1));
        h_m1_next     = ROW_W'(h_val - DIM_W'(1));
        out_h_m1_next = h_one_next ? '0 : YW'((h_val >> 1) - DIM_W'(1));
    end

    // Take configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_one_reg    <= 1'b1;
            w_m1_reg     <= '0;
            out_w_m1_reg <= '0;
            h_one_reg    <= 1'b1;
            h_m1_reg     <= '0;
            out_h_m1_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_IMAGE_WIDTH: begin
                    w_one_reg    <= w_one_next;
                    w_m1_reg     <= w_m1_next;
                    out_w_m1_reg <= out_w_m1_next;
                end
                REG_IMAGE_HEIGHT: begin
                    h_one_reg    <= h_one_next;
                    h_m1_reg     <= h_m1_next;
                    out_h_m1_reg <= out_h_m1_next;
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input side: position, horizontal pairing, line store access
    // ------------------------------------------------------------------
    logic             accept;
    logic [CW-1:0]    col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [PIX_W-1:0] held_reg;
    logic [XW-1:0]    xh;
    logic [YW-1:0]    yh;
    logic             pair_ready;
    logic             row_in_range;
    logic             emit;
    logic             last_pix;
    logic             line_we;
    logic             line_re;
    hsum_t            hsum [NUM_CHAN];
    logic [LINE_W-1:0] line_wdata;
    logic [LINE_W-1:0] line_rdata;

    assign accept = s_tvalid && s_tready;
    assign xh     = col_reg[CW-1:1];
    assign yh     = row_reg[ROW_W-1:1];

    always_comb begin
        for (int k = 0; k < NUM_CHAN; k++) begin
            if (w_one_reg) begin
                hsum[k] = {s_tdata[k*CHAN_W +: CHAN_W], 1'b0};
            end else begin
                hsum[k] = {1'b0, held_reg[k*CHAN_W +: CHAN_W]}
                        + {1'b0, s_tdata[k*CHAN_W +: CHAN_W]};
            end
            line_wdata[k*LINE_FIELD_W +: LINE_FIELD_W] = LINE_FIELD_W'(hsum[k]);
        end
    end

    // Decide what this pixel completes
    always_comb begin
        if (w_one_reg) begin
            pair_ready = (col_reg == '0);
        end else begin
            pair_ready = col_reg[0] && (xh <= out_w_m1_reg);
        end
        row_in_range = (yh <= out_h_m1_reg);
        if (h_one_reg) begin
            emit = pair_ready && (row_reg == '0);
        end else begin
            emit = pair_ready && row_reg[0] && row_in_range;
        end
        last_pix = (w_one_reg || (xh == out_w_m1_reg))
                && (h_one_reg || (yh == out_h_m1_reg));
        line_we  = accept && pair_ready && !h_one_reg && !row_reg[0] && row_in_range;
        line_re  = accept && pair_ready && !h_one_reg && row_reg[0] && row_in_range;
    end

    // Advance the raster position and hold the left pixel of each pair
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            held_reg <= '0;
        end else if (accept) begin
            if (!w_one_reg && !col_reg[0]) begin
                held_reg <= s_tdata;
            end
            if (col_reg >= w_m1_reg) begin
                col_reg <= '0;
                row_reg <= (row_reg >= h_m1_reg) ? '0 : row_reg + ROW_W'(1);
            end else begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    bds2x_ram #(
        .WIDTH (LINE_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .aclk    (aclk),
        .wr_en   (line_we),
        .wr_addr (AW'(xh)),
        .wr_data (line_wdata),
        .rd_en   (line_re),
        .rd_addr (AW'(xh)),
        .rd_data (line_rdata)
    );

    // ------------------------------------------------------------------
    // Pair stage: waits beside the line store read
    // ------------------------------------------------------------------
    logic  s1_valid_reg;
    logic  s1_double_reg;
    logic  s1_last_reg;
    hsum_t s1_hsum_reg [NUM_CHAN];
    logic  s1_adv;

    assign s1_adv   = !m_tvalid || m_tready;
    assign s_tready = !s1_valid_reg || s1_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= accept && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            s1_double_reg <= h_one_reg;
            s1_last_reg   <= last_pix;
            for (int k = 0; k < NUM_CHAN; k++) begin
                s1_hsum_reg[k] <= hsum[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register: finish the 2x2 sum and round
    // ------------------------------------------------------------------
    logic             m_tvalid_reg;
    logic             m_tlast_reg;
    logic [PIX_W-1:0] m_tdata_reg, m_tdata_next;
    logic [LINE_FIELD_W:0] sum [NUM_CHAN];
    logic [LINE_FIELD_W:0] rounded [NUM_CHAN];

    always_comb begin
        for (int k = 0; k < NUM_CHAN; k++) begin
            if (s1_double_reg) begin
                sum[k] = (LINE_FIELD_W+1)'({s1_hsum_reg[k], 1'b0});
            end else begin
                sum[k] = (LINE_FIELD_W+1)'(line_rdata[k*LINE_FIELD_W +: LINE_FIELD_W])
                       + (LINE_FIELD_W+1)'(s1_hsum_reg[k]);
            end
            rounded[k] = sum[k] + (LINE_FIELD_W+1)'(2);
            m_tdata_next[k*CHAN_W +: CHAN_W] = rounded[k][CHAN_W+1:2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_tvalid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_tdata_reg <= m_tdata_next;
            m_tlast_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_line_port_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(line_we && line_re))
        else $error("line store written and read in one cycle");

    a_pair_to_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_adv) |=> m_tvalid_reg)
        else $error("pair stage result lost on its way to the output");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && m_tvalid_reg && !m_tready) |-> !s_tready)
        else $error("source transfer taken with both stages full");

    a_we_needs_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        (line_we || line_re) |-> (accept && pair_ready))
        else $error("line store access without a completed pair");

endmodule

`default_nettype wire

/* dv/bds2x_checker.sv */
// ----------------------------------------------------------------------------
// bds2x_checker
// Watches the pixel streams of the 2x2 box downsampler and checks its results.
// ----------------------------------------------------------------------------
// Follows the configuration writes and every source pixel transfer, works out
// the downsampled pixel that each transfer completes, and compares every
// result transfer field by field with the oldest pixel still awaited.
// ----------------------------------------------------------------------------

module bds2x_checker #(
    parameter int MAX_WIDTH = bds2x_pkg::MAX_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  bds2x_pkg::cfg_idx_t           cfg_addr,
    input  logic [bds2x_pkg::DIM_W-1:0]   cfg_wr_data,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [bds2x_pkg::PIX_W-1:0]   s_tdata,   // chan0, chan1, chan2, chan3
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [bds2x_pkg::PIX_W-1:0]   m_tdata,   // out_chan0..out_chan3
    input  logic                          m_tlast,   // last_of_image
    output int                            mismatch_count,
    output int                            pending_pixels,
    output int                            checked_pixels
);
    timeunit 1ns;
    timeprecision 1ps;

    import bds2x_pkg::*;

    localparam int LINE_DEPTH = MAX_WIDTH / 2;

    typedef struct packed {
        logic                      last;
        chan_t [NUM_CHAN-1:0]      chans;
    } down_pix_t;

    // Own copy of the block's state and registers
    logic [LINE_W-1:0]  pair_sums [0:LINE_DEPTH-1];
    logic [PIX_W-1:0]   held_left;
    int unsigned        col_pos;
    int unsigned        row_pos;
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;

    down_pix_t          expected_pixels [$];

    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v,
                                              input int unsigned hi);
        if (v == '0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    // Advance the downsampler by one source pixel; queue the result it completes
    function automatic void predict_downsample(input logic [PIX_W-1:0] pix);
        int unsigned w, h, ow, oh, x, y;
        int unsigned hsum [NUM_CHAN];
        int unsigned total [NUM_CHAN];
        bit          pair_ok, emit;
        down_pix_t   res;

        w  = clamp_dim(width_reg, MAX_WIDTH);
        h  = clamp_dim(height_reg, HEIGHT_LIMIT);
        ow = (w / 2 > 1) ? w / 2 : 1;
        oh = (h / 2 > 1) ? h / 2 : 1;
        pair_ok = 1'b0;
        emit    = 1'b0;
        x       = 0;

        // Horizontal pair: a single column counts its pixel twice
        if (w == 1) begin
            if (col_pos == 0) begin
                for (int k = 0; k < NUM_CHAN; k++)
                    hsum[k] = 2 * pix[CHAN_W*k +: CHAN_W];
                pair_ok = 1'b1;
            end
        end else if (col_pos % 2 == 0) begin
            held_left = pix;
        end else if (col_pos < 2 * ow) begin
            for (int k = 0; k < NUM_CHAN; k++)
                hsum[k] = held_left[CHAN_W*k +: CHAN_W] + pix[CHAN_W*k +: CHAN_W];
            pair_ok = 1'b1;
            x = col_pos / 2;
        end

        // Vertical pair: even rows store, odd rows complete
        if (pair_ok) begin
            if (h == 1) begin
                if (row_pos == 0) begin
                    for (int k = 0; k < NUM_CHAN; k++)
                        total[k] = 2 * hsum[k];
                    emit = 1'b1;
                end
            end else if (row_pos < 2 * oh && x < LINE_DEPTH) begin
                if (row_pos % 2 == 0) begin
                    for (int k = 0; k < NUM_CHAN; k++)
                        pair_sums[x][LINE_FIELD_W*k +: LINE_FIELD_W] =
                            LINE_FIELD_W'(hsum[k]);
                end else begin
                    for (int k = 0; k < NUM_CHAN; k++)
                        total[k] = pair_sums[x][LINE_FIELD_W*k +: LINE_FIELD_W] + hsum[k];
                    emit = 1'b1;
                end
            end
        end

        if (emit) begin
            y = (h == 1) ? 0 : row_pos / 2;
            for (int k = 0; k < NUM_CHAN; k++)
                res.chans[k] = chan_t'((total[k] + 2) >> 2);
            res.last = (x == ow - 1) && (y == oh - 1);
            expected_pixels.push_back(res);
        end

        // Step the raster position, wrapping at the end of the image
        if (col_pos >= w - 1) begin
            col_pos = 0;
            row_pos = (row_pos >= h - 1) ? 0 : row_pos + 1;
        end else begin
            col_pos = col_pos + 1;
        end
    endfunction

    always @(posedge aclk) begin : watch
        down_pix_t want;

        if (!aresetn) begin
            held_left      = '0;
            col_pos        = 0;
            row_pos        = 0;
            width_reg      = 1;
            height_reg     = 1;
            mismatch_count = 0;
            checked_pixels = 0;
            expected_pixels.delete();
        end else begin
            // Follow register writes
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_IMAGE_WIDTH:  width_reg  = cfg_wr_data;
                    REG_IMAGE_HEIGHT: height_reg = cfg_wr_data;
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
                predict_downsample(s_tdata);

            // Compare each result transfer with the oldest awaited pixel
            if (m_tvalid && m_tready) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected result: data %h last %b", m_tdata, m_tlast);
                    mismatch_count++;
                end else begin
                    want = expected_pixels.pop_front();
                    for (int k = 0; k < NUM_CHAN; k++) begin
                        if (m_tdata[CHAN_W*k +: CHAN_W] !== want.chans[k]) begin
                            $error("out_chan%0d: expected %0d, got %0d",
                                   k, want.chans[k], m_tdata[CHAN_W*k +: CHAN_W]);
                            mismatch_count++;
                        end
                    end
                    if (m_tlast !== want.last) begin
                        $error("last_of_image: expected %0d, got %0d", want.last, m_tlast);
                        mismatch_count++;
                    end
                    checked_pixels++;
                end
            end
        end
        pending_pixels = expected_pixels.size();
    end

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the 2x2 box downsampler.
// ----------------------------------------------------------------------------
// Streams whole images through the block under a range of image sizes, from
// single pixels up to some sixty columns and rows, including zero register
// values and odd edges. Registers change only between images, once every
// awaited result has arrived. The source and result sides idle in rotating
// phases. The checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bds2x_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_phase_t;
    typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_FULL, FILL_EXTREME} pixel_fill_t;

    localparam int          SETTLE_CYCLES = 8;
    localparam int          DRAIN_CYCLES  = 16;
    localparam int          RANDOM_ITEMS  = 1550;

    logic               aclk;
    logic               aresetn     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    cfg_idx_t           cfg_addr    = REG_IMAGE_WIDTH;
    logic [DIM_W-1:0]   cfg_wr_data = '0;
    logic               s_tvalid    = 1'b0;
    logic               s_tready;
    logic [PIX_W-1:0]   s_tdata     = '0;   // chan0, chan1, chan2, chan3
    logic               m_tvalid;
    logic               m_tready    = 1'b0;
    logic [PIX_W-1:0]   m_tdata;            // out_chan0..out_chan3
    logic               m_tlast;            // last_of_image

    int unsigned        idle_pct  = 0;
    int unsigned        stall_pct = 0;
    int                 source_count = 0;
    int                 image_count  = 0;
    int                 mismatch_count;
    int                 pending_pixels;
    int                 checked_pixels;

    box_downsample_2x_rgba u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    bds2x_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wr_data    (cfg_wr_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .pending_pixels (pending_pixels),
        .checked_pixels (checked_pixels)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    // Result side: stall at the rate of the current phase
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [PIX_W-1:0] make_pixel(input pixel_fill_t fill);
        logic [PIX_W-1:0] pix;
        case (fill)
            FILL_ZERO: pix = '0;
            FILL_FULL: pix = '1;
            FILL_EXTREME: begin
                for (int k = 0; k < NUM_CHAN; k++)
                    pix[CHAN_W*k +: CHAN_W] = $urandom_range(1) ? '1 : '0;
            end
            default: pix = $urandom;
        endcase
        return pix;
    endfunction

    // Mostly small sizes, now and then a zero register value
    function automatic logic [DIM_W-1:0] pick_dim();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 6)
            return '0;
        if (roll < 85)
            return DIM_W'($urandom_range(10, 1));
        return DIM_W'($urandom_range(64, 11));
    endfunction

    // One pixel transfer; called and returns at a falling edge
    task automatic send_pixel(input logic [PIX_W-1:0] pix);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        source_count++;
    endtask

    // Settle the block, write both registers, then stream whole images
    task automatic run_images(input logic [DIM_W-1:0] w_val,
                              input logic [DIM_W-1:0] h_val,
                              input int unsigned frames,
                              input pixel_fill_t fill,
                              input idle_phase_t phase);
        int unsigned w, h;

        // Hold the source until every awaited result has come out
        while (pending_pixels != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);

        case (phase)
            IDLE_SENDER:   begin idle_pct = 62; stall_pct = 0;  end
            IDLE_RECEIVER: begin idle_pct = 0;  stall_pct = 62; end
            IDLE_BOTH:     begin idle_pct = 37; stall_pct = 37; end
            default:       begin idle_pct = 0;  stall_pct = 0;  end
        endcase

        cfg_wr_en   <= 1'b1;
        cfg_addr    <= REG_IMAGE_WIDTH;
        cfg_wr_data <= w_val;
        @(negedge aclk);
        cfg_addr    <= REG_IMAGE_HEIGHT;
        cfg_wr_data <= h_val;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;

        // Pixel count follows the clamped dimensions
        w = (w_val == '0) ? 1 : ((w_val > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w_val);
        h = (h_val == '0) ? 1 : ((h_val > HEIGHT_LIMIT) ? HEIGHT_LIMIT : h_val);
        repeat (frames * w * h) send_pixel(make_pixel(fill));
        s_tvalid <= 1'b0;
        image_count += frames;
    endtask

    initial begin : stimulus
        int random_start;

        aresetn <= 1'b0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: saturated and empty pixels, rounding on mixed extremes,
        // dropped odd column and row, zero registers, single column
        run_images(2, 2, 1, FILL_FULL,    IDLE_NONE);
        run_images(2, 2, 1, FILL_ZERO,    IDLE_NONE);
        run_images(2, 2, 1, FILL_EXTREME, IDLE_NONE);
        run_images(3, 3, 1, FILL_RANDOM,  IDLE_NONE);
        run_images(0, 0, 1, FILL_RANDOM,  IDLE_NONE);
        run_images(1, 2, 1, FILL_EXTREME, IDLE_NONE);

        // Wider odd image, a tall single column and a single row under idling
        run_images(65, 5, 1, FILL_RANDOM, IDLE_BOTH);
        run_images(1, 33, 1, FILL_RANDOM, IDLE_SENDER);
        run_images(64, 1, 1, FILL_EXTREME, IDLE_RECEIVER);

        // Random sizes and content, rotating through the idling phases
        random_start = source_count;
        while (source_count - random_start < RANDOM_ITEMS)
            run_images(pick_dim(), pick_dim(), $urandom_range(2, 1),
                       ($urandom_range(9) == 0) ? FILL_EXTREME : FILL_RANDOM,
                       idle_phase_t'(image_count % 4));

        // Drain, then allow for the block's pipeline
        while (pending_pixels != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("tb_top: %0d source pixels in %0d images, %0d downsampled pixels compared",
                 source_count, image_count, checked_pixels);
        $display("tb_top: sizes 1 to 65 with zero settings and odd edges, four idling phases");
        if (mismatch_count == 0 && pending_pixels == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
